// ===== rtl/core/lfpd_pkg.sv =====
package lfpd_pkg;

    // Payload and configuration widths.
    localparam int SENSOR_W   = 8;
    localparam int LINE_ERR_W = 10;
    localparam int DIFF_W     = 11;
    localparam int DRIVE_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Fixed drive limits and the pattern that clears the loop state.
    localparam int DRIVE_MAX  = 1000;
    localparam int DRIVE_MIN  = 100;
    localparam int BASE_FLOOR = 100;
    localparam int BASE_CEIL  = 900;
    localparam logic [SENSOR_W-1:0] CENTER_PAIR_MASK = 8'd24;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 12;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Reduction divider: 20-bit dividend, 10-bit divisor and quotient.
    localparam int DVD_W     = 20;
    localparam int DVS_W     = 10;
    localparam int QUO_W     = 10;
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P       = 3'd0,
        CFG_GAIN_D       = 3'd1,
        CFG_BASE_DRIVE   = 3'd2,
        CFG_FILTER_ALPHA = 3'd3,
        CFG_DELTA_LIMIT  = 3'd4,
        CFG_GUARD_RATIO  = 3'd5,
        CFG_DIFF_LIMIT   = 3'd6,
        CFG_REDUCE_MAX   = 3'd7
    } t_cfg_idx;

    // Center position of each sensor, bit 0 leftmost.
    localparam logic signed [LINE_ERR_W-1:0] SENSOR_POS [SENSOR_W] = '{
        -10'sd280, -10'sd200, -10'sd120, -10'sd40,
        10'sd40, 10'sd120, 10'sd200, 10'sd280
    };

    // Midpoint of the first and last active sensors, zero when none is active.
    function automatic logic signed [LINE_ERR_W-1:0] decode_error(
        input logic [SENSOR_W-1:0] bits
    );
        logic [2:0] lo;
        logic [2:0] hi;
        logic signed [LINE_ERR_W:0] sum;
        lo = '0;
        hi = '0;
        for (int i = SENSOR_W - 1; i >= 0; i--) begin
            if (bits[i]) begin
                lo = 3'(i);
            end
        end
        for (int i = 0; i < SENSOR_W; i++) begin
            if (bits[i]) begin
                hi = 3'(i);
            end
        end
        sum = {SENSOR_POS[lo][LINE_ERR_W-1], SENSOR_POS[lo]}
            + {SENSOR_POS[hi][LINE_ERR_W-1], SENSOR_POS[hi]};
        // The sum is always a multiple of 80, so halving is exact.
        return (bits == '0) ? '0 : sum[LINE_ERR_W:1];
    endfunction

endpackage

// ===== rtl/core/lfpd_if.sv =====
interface lfpd_in_if import lfpd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SENSOR_W-1:0] sensor_bits;

    modport source (output valid, output sensor_bits, input ready);
    modport sink   (input valid, input sensor_bits, output ready);
endinterface

interface lfpd_out_if import lfpd_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [LINE_ERR_W-1:0] line_error;
    logic signed [DIFF_W-1:0]     diff_drive;
    logic [DRIVE_W-1:0]           left_drive;
    logic [DRIVE_W-1:0]           right_drive;

    modport source (output valid, output line_error, output diff_drive,
                    output left_drive, output right_drive, input ready);
    modport sink   (input valid, input line_error, input diff_drive,
                    input left_drive, input right_drive, output ready);
endinterface

// ===== rtl/core/line_follow_pd_drive.sv =====
// Line follower steering controller with PD loop and differential wheel mix.
//
// Input channel i_in carries one 8-bit sensor pattern per item (bit 0 is the
// leftmost sensor). Output channel o_out returns one result item per input
// item: the decoded line error, the clamped differential drive and the two
// wheel drives. Both channels use a valid/ready handshake; an item moves on a
// rising edge with valid and ready high. Eight tuning registers are written
// through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only
// while the block is idle, as the block itself does not enforce this.
//
// One item is handled at a time by a sequencer around a single shared
// multiplier and a bit-serial divider; the ten steps of the divider are the
// largest share of an item. A clearing pattern (all off, or the center pair)
// skips the filter and PD steps. The input is ready again as the result is
// loaded, so a new item waits until the last one has left the sequencer.
//
// Reset loads the register defaults and clears the filter state. A stalled
// receiver holds the result in the output register; a finished next item
// waits in its last step until that register frees up.
module line_follow_pd_drive import lfpd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lfpd_in_if.sink               i_in,
    lfpd_out_if.source            o_out
);

    // One-hot sequencer states, one per step of an item.
    typedef enum logic [15:0] {
        S_IDLE  = 16'b0000_0000_0000_0001,
        S_FMUL  = 16'b0000_0000_0000_0010,
        S_FUPD  = 16'b0000_0000_0000_0100,
        S_FINT  = 16'b0000_0000_0000_1000,
        S_PMUL  = 16'b0000_0000_0001_0000,
        S_DMUL  = 16'b0000_0000_0010_0000,
        S_GMUL1 = 16'b0000_0000_0100_0000,
        S_GMUL2 = 16'b0000_0000_1000_0000,
        S_GUARD = 16'b0000_0001_0000_0000,
        S_CLAMP = 16'b0000_0010_0000_0000,
        S_DIFF  = 16'b0000_0100_0000_0000,
        S_RMUL  = 16'b0000_1000_0000_0000,
        S_DIVS  = 16'b0001_0000_0000_0000,
        S_DIVW  = 16'b0010_0000_0000_0000,
        S_EFF   = 16'b0100_0000_0000_0000,
        S_OUT   = 16'b1000_0000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Tuning registers.
    logic [15:0] r_gain_p;
    logic [15:0] r_gain_d;
    logic [9:0]  r_base;
    logic [8:0]  r_alpha;
    logic [9:0]  r_delta_lim;
    logic [8:0]  r_guard;
    logic [9:0]  r_diff_lim;
    logic [9:0]  r_reduce_max;

    // Loop state: filter in Q10.8 and the last integer filtered error.
    logic signed [17:0] r_filt;
    logic signed [9:0]  r_prev;

    // Per-item working registers.
    logic signed [LINE_ERR_W-1:0] r_err;
    logic signed [9:0]            r_fint;
    logic signed [10:0]           r_delta;
    logic signed [27:0]           r_acc;
    logic signed [DIFF_W-1:0]     r_diff;
    logic [DRIVE_W-1:0]           r_eff;

    // Output register.
    logic                         r_out_valid;
    logic signed [LINE_ERR_W-1:0] r_out_err;
    logic signed [DIFF_W-1:0]     r_out_diff;
    logic [DRIVE_W-1:0]           r_out_left;
    logic [DRIVE_W-1:0]           r_out_right;

    logic                      in_accept;
    logic                      in_clear;
    logic                      out_free;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_prod;
    logic                      div_start;
    logic                      div_done;
    logic [QUO_W-1:0]          div_quo;

    logic [8:0]         alpha_sat;
    logic signed [18:0] f_diff;
    logic signed [26:0] step_t;
    logic signed [18:0] filt_sum;
    logic signed [18:0] fint_t;
    logic signed [10:0] delta_raw;
    logic signed [10:0] delta_lim;
    logic signed [35:0] guard_t;
    logic               acc_flip;
    logic signed [27:0] acc_lim;
    logic signed [27:0] acc_t;
    logic signed [10:0] abs_t;
    logic [9:0]         abs_diff;
    logic signed [11:0] eff_raw;
    logic signed [11:0] left_raw;
    logic signed [11:0] right_raw;

    // Wheel clamp: above the maximum saturates, zero or below stops the
    // wheel, and a small positive drive is raised to the minimum.
    function automatic logic [DRIVE_W-1:0] wheel_clamp(input logic signed [11:0] v);
        logic [DRIVE_W-1:0] res;
        priority if (v > $signed(12'(DRIVE_MAX))) begin
            res = DRIVE_W'(DRIVE_MAX);
        end else if (v <= 12'sd0) begin
            res = '0;
        end else if (v < $signed(12'(DRIVE_MIN))) begin
            res = DRIVE_W'(DRIVE_MIN);
        end else begin
            res = v[DRIVE_W-1:0];
        end
        return res;
    endfunction

    assign in_accept = i_in.valid && i_in.ready;
    assign in_clear  = (i_in.sensor_bits == '0) || (i_in.sensor_bits == CENTER_PAIR_MASK);
    assign out_free  = !r_out_valid || o_out.ready;
    assign div_start = (r_state == S_DIVS);

    // Datapath terms. Every divide by 256 truncates toward zero, done by
    // adding 255 to a negative value before dropping the low byte.
    always_comb begin
        alpha_sat = (r_alpha > 9'd256) ? 9'd256 : r_alpha;
        f_diff    = {r_err[LINE_ERR_W-1], r_err, 8'h00} - {r_filt[17], r_filt};
        step_t    = mul_prod[26:0] + (mul_prod[26] ? 27'sd255 : 27'sd0);
        filt_sum  = {r_filt[17], r_filt} + step_t[26:8];
        fint_t    = {r_filt[17], r_filt} + (r_filt[17] ? 19'sd255 : 19'sd0);
        delta_raw = {r_fint[9], r_fint} - {r_prev[9], r_prev};
        delta_lim = {1'b0, r_delta_lim};
        guard_t   = mul_prod[35:0] + (mul_prod[35] ? 36'sd255 : 36'sd0);
        // The guard applies when the PD sum opposes the raw error.
        acc_flip  = (!r_err[LINE_ERR_W-1] && (r_err != '0) && r_acc[27])
                 || (r_err[LINE_ERR_W-1] && !r_acc[27] && (r_acc != '0));
        acc_lim   = {10'd0, r_diff_lim, 8'h00};
        acc_t     = r_acc + (r_acc[27] ? 28'sd255 : 28'sd0);
        abs_t     = r_diff[DIFF_W-1] ? -r_diff : r_diff;
        abs_diff  = abs_t[9:0];
        eff_raw   = {2'b00, r_base} - {2'b00, div_quo};
        left_raw  = {2'b00, r_eff} + {r_diff[DIFF_W-1], r_diff};
        right_raw = {2'b00, r_eff} - {r_diff[DIFF_W-1], r_diff};
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_FMUL: begin
                mul_a = MUL_A_W'(f_diff);
                mul_b = {3'b000, alpha_sat};
            end
            S_PMUL: begin
                mul_a = {10'd0, r_gain_p};
                mul_b = {{2{r_fint[9]}}, r_fint};
            end
            S_DMUL: begin
                mul_a = {10'd0, r_gain_d};
                mul_b = {r_delta[10], r_delta};
            end
            S_GMUL1: begin
                mul_a = {10'd0, r_gain_p};
                mul_b = {3'b000, r_guard};
            end
            S_GMUL2: begin
                // Guard ratio times gain is at most 25 bits, unsigned.
                mul_a = {1'b0, mul_prod[24:0]};
                mul_b = {{2{r_err[LINE_ERR_W-1]}}, r_err};
            end
            S_RMUL: begin
                mul_a = {16'd0, abs_diff};
                mul_b = {2'b00, r_reduce_max};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lfpd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    // The differential is already clamped to the divisor, so the quotient
    // fits ten bits and the divider needs only ten steps.
    lfpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_prod[DVD_W-1:0]),
        .i_divisor  (r_diff_lim),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = in_clear ? S_RMUL : S_FMUL;
                end
            end
            S_FMUL:  n_state = S_FUPD;
            S_FUPD:  n_state = S_FINT;
            S_FINT:  n_state = S_PMUL;
            S_PMUL:  n_state = S_DMUL;
            S_DMUL:  n_state = S_GMUL1;
            S_GMUL1: n_state = S_GMUL2;
            S_GMUL2: n_state = S_GUARD;
            S_GUARD: n_state = S_CLAMP;
            S_CLAMP: n_state = S_DIFF;
            S_DIFF:  n_state = S_RMUL;
            S_RMUL:  n_state = S_DIVS;
            S_DIVS:  n_state = S_DIVW;
            S_DIVW: begin
                if (div_done) begin
                    n_state = S_EFF;
                end
            end
            S_EFF:   n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, tuning registers and loop state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_gain_p     <= 16'd256;
            r_gain_d     <= 16'd0;
            r_base       <= 10'd500;
            r_alpha      <= 9'd128;
            r_delta_lim  <= 10'd80;
            r_guard      <= 9'd128;
            r_diff_lim   <= 10'd400;
            r_reduce_max <= 10'd200;
            r_filt       <= '0;
            r_prev       <= '0;
        end else begin
            r_state <= n_state;

            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_GAIN_P:       r_gain_p     <= i_cfg_data;
                    CFG_GAIN_D:       r_gain_d     <= i_cfg_data;
                    CFG_BASE_DRIVE:   r_base       <= i_cfg_data[9:0];
                    CFG_FILTER_ALPHA: r_alpha      <= i_cfg_data[8:0];
                    CFG_DELTA_LIMIT:  r_delta_lim  <= i_cfg_data[9:0];
                    CFG_GUARD_RATIO:  r_guard      <= i_cfg_data[8:0];
                    CFG_DIFF_LIMIT:   r_diff_lim   <= i_cfg_data[9:0];
                    CFG_REDUCE_MAX:   r_reduce_max <= i_cfg_data[9:0];
                    default:          r_gain_p     <= r_gain_p;
                endcase
            end

            if (in_accept && in_clear) begin
                r_filt <= '0;
                r_prev <= '0;
            end else if (r_state == S_FUPD) begin
                r_filt <= filt_sum[17:0];
            end else if (r_state == S_PMUL) begin
                r_prev <= r_fint;
            end
        end
    end

    // Per-item working registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_err  <= decode_error(i_in.sensor_bits);
                    r_diff <= '0;
                end
            end
            S_FINT: begin
                r_fint <= fint_t[17:8];
            end
            S_PMUL: begin
                priority if (delta_raw > delta_lim) begin
                    r_delta <= delta_lim;
                end else if (delta_raw < -delta_lim) begin
                    r_delta <= -delta_lim;
                end else begin
                    r_delta <= delta_raw;
                end
            end
            S_DMUL: begin
                r_acc <= mul_prod[27:0];
            end
            S_GMUL1: begin
                r_acc <= r_acc + mul_prod[27:0];
            end
            S_GUARD: begin
                if (acc_flip) begin
                    r_acc <= guard_t[35:8];
                end
            end
            S_CLAMP: begin
                priority if (r_acc > acc_lim) begin
                    r_acc <= acc_lim;
                end else if (r_acc < -acc_lim) begin
                    r_acc <= -acc_lim;
                end
            end
            S_DIFF: begin
                r_diff <= acc_t[18:8];
            end
            S_EFF: begin
                priority if (eff_raw < $signed(12'(BASE_FLOOR))) begin
                    r_eff <= DRIVE_W'(BASE_FLOOR);
                end else if (eff_raw > $signed(12'(BASE_CEIL))) begin
                    r_eff <= DRIVE_W'(BASE_CEIL);
                end else begin
                    r_eff <= eff_raw[DRIVE_W-1:0];
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_err   <= r_err;
                    r_out_diff  <= r_diff;
                    r_out_left  <= wheel_clamp(left_raw);
                    r_out_right <= wheel_clamp(right_raw);
                end
            end
            default: begin
                r_eff <= r_eff;
            end
        endcase
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.line_error  = r_out_err;
    assign o_out.diff_drive  = r_out_diff;
    assign o_out.left_drive  = r_out_left;
    assign o_out.right_drive = r_out_right;

    a_result_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_out_valid) |=> r_out_valid)
        else $error("finished item not loaded into output register");
    a_diff_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMUL) |-> ((r_diff <= $signed({1'b0, r_diff_lim}))
                              && (r_diff >= -$signed({1'b0, r_diff_lim}))))
        else $error("differential drive outside its limit");
    a_reduce_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EFF) |-> (div_quo <= r_reduce_max))
        else $error("speed reduction above its maximum");
    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && in_clear) |=> (r_filt == '0 && r_prev == '0))
        else $error("clearing pattern left loop state set");

endmodule

// ===== rtl/core/lfpd_mul.sv =====
module lfpd_mul import lfpd_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_prod
);

    logic signed [MUL_P_W-1:0] r_prod;

    // Product is registered so the next step starts from a flop.
    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/core/lfpd_div.sv =====
module lfpd_div import lfpd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_quo;
    logic [DVS_W-1:0]     r_div;
    logic                 r_zero;

    logic [DVS_W:0]   trial;
    logic             n_bit;
    logic [DVS_W-1:0] n_rem;

    // Restoring division, one quotient bit per cycle. The caller guarantees
    // that the upper half of the dividend is below the divisor.
    always_comb begin
        trial = {r_rem, r_quo[QUO_W-1]};
        n_bit = (trial >= {1'b0, r_div});
        n_rem = n_bit ? DVS_W'(trial - {1'b0, r_div}) : trial[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend[DVD_W-1:QUO_W];
            r_quo  <= i_dividend[QUO_W-1:0];
            r_div  <= i_divisor;
            r_zero <= (i_divisor == '0);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[QUO_W-2:0], n_bit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_zero ? '0 : r_quo;

    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !r_busy) |=> (r_busy && r_cnt == DIV_CNT_W'(DIV_STEPS)))
        else $error("divider did not start");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_zero) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

endmodule

// ===== dv/line_follow_pd_drive_test.sv =====
module line_follow_pd_drive_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lfpd_pkg::*;

    // One decoded result item as the block should return it.
    typedef struct packed {
        logic signed [LINE_ERR_W-1:0] line_error;
        logic signed [DIFF_W-1:0]     diff_drive;
        logic [DRIVE_W-1:0]           left_drive;
        logic [DRIVE_W-1:0]           right_drive;
    } t_drive_result;

    // The watchdog gives up after this many cycles without any item moving.
    // The longest legal quiet stretch is the long receiver hold-off plus a
    // long gap and one item of processing, well under this.
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_CYCLES     = 400;
    localparam int RANDOM_PHASES   = 13;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int SETTLE_CYCLES   = 30;

    // Per-register masks, reset values and the range most random settings
    // are drawn from, in register index order.
    localparam logic [CFG_DATA_W-1:0] REG_MASK [8] = '{
        16'hFFFF, 16'hFFFF, 16'h03FF, 16'h01FF, 16'h03FF, 16'h01FF, 16'h03FF, 16'h03FF
    };
    localparam int REG_RESET [8]   = '{256, 0, 500, 128, 80, 128, 400, 200};
    localparam int REG_TYPICAL [8] = '{1536, 4096, 1000, 256, 560, 256, 1000, 1000};

    // Directed patterns at the reset settings: empty, both ends, all on,
    // the center pair, single inner sensors, wide spans and sparse patterns.
    localparam logic [SENSOR_W-1:0] DIRECTED_RESET [14] = '{
        8'h00, 8'h01, 8'h80, 8'hFF, 8'h18, 8'h10, 8'h08,
        8'h81, 8'h7E, 8'h02, 8'h40, 8'h55, 8'hAA, 8'h00
    };
    // Directed patterns with a slow filter: the line sits far left long
    // enough that a jump to the far right leaves the filtered error on the
    // wrong side, which must trip the sign guard.
    localparam logic [SENSOR_W-1:0] DIRECTED_GUARD [10] = '{
        8'h01, 8'h01, 8'h01, 8'h80, 8'h80, 8'h18, 8'hC0, 8'h03, 8'hF0, 8'h00
    };

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    // Testbench-owned drive registers, so that every input is known at time 0.
    logic                  drv_valid = 1'b0;
    logic [SENSOR_W-1:0]   drv_bits  = '0;
    logic                  mon_ready = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    lfpd_in_if  in_ch ();
    lfpd_out_if out_ch ();

    assign in_ch.valid       = drv_valid;
    assign in_ch.sensor_bits = drv_bits;
    assign out_ch.ready      = mon_ready;

    line_follow_pd_drive dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Shadow copy of the tuning registers as the block holds them.
    logic [15:0] cfg_gain_p    = 16'd256;
    logic [15:0] cfg_gain_d    = 16'd0;
    logic [9:0]  cfg_base      = 10'd500;
    logic [8:0]  cfg_alpha     = 9'd128;
    logic [9:0]  cfg_delta_lim = 10'd80;
    logic [8:0]  cfg_guard     = 9'd128;
    logic [9:0]  cfg_diff_lim  = 10'd400;
    logic [9:0]  cfg_reduce    = 10'd200;

    // Loop state: low-pass filter in Q10.8 and the last integer filtered error.
    logic signed [17:0] filt_q8  = '0;
    logic signed [9:0]  prev_int = '0;

    logic [SENSOR_W-1:0] pending_patterns [$];
    t_drive_result       expected_drive [$];

    int  fail_count   = 0;
    int  items_sent   = 0;
    int  results_seen = 0;
    int  guard_hits   = 0;
    int  clear_hits   = 0;
    int  settings_run = 0;
    int  gap_left     = 0;
    int  stall_left   = 0;
    int  hold_left    = 0;
    int  idle_cycles  = 0;
    int  line_pos     = 3;
    bit  no_idle      = 1'b0;

    logic          next_valid;
    logic [7:0]    next_bits;
    logic          next_ready;
    t_drive_result want;

    // Wheel limits: saturate high, a non-positive drive stops the wheel,
    // and a small positive drive is raised to the minimum.
    function automatic longint clamp_wheel(longint v);
        if (v > DRIVE_MAX) return DRIVE_MAX;
        if (v <= 0) return 0;
        if (v < DRIVE_MIN) return DRIVE_MIN;
        return v;
    endfunction

    // Works out the result for one sensor pattern and advances the loop state.
    function automatic t_drive_result predict_drive(logic [SENSOR_W-1:0] bits);
        t_drive_result r;
        longint err, alpha, f, fint, delta, lim_d, gp, gd, acc, lim, diff;
        longint mag, cut, eff;
        int lo, hi;
        lo = -1;
        hi = -1;
        for (int i = 0; i < SENSOR_W; i++) begin
            if (bits[i]) begin
                if (lo < 0) lo = i;
                hi = i;
            end
        end
        // Sensor i sits at 80*i - 280; the error is the midpoint of the
        // outermost active sensors.
        err  = (lo < 0) ? 0 : ((80 * lo - 280) + (80 * hi - 280)) / 2;
        diff = 0;
        if (bits == '0 || bits == CENTER_PAIR_MASK) begin
            // Lost line or centered pair: the loop restarts from rest.
            filt_q8  = '0;
            prev_int = '0;
            clear_hits++;
        end else begin
            alpha = (cfg_alpha > 9'd256) ? 256 : longint'(cfg_alpha);
            f     = filt_q8;
            f     = f + (alpha * (err * 256 - f)) / 256;
            fint  = f / 256;
            lim_d = cfg_delta_lim;
            delta = fint - longint'(prev_int);
            if (delta > lim_d) delta = lim_d;
            else if (delta < -lim_d) delta = -lim_d;
            gp  = cfg_gain_p;
            gd  = cfg_gain_d;
            acc = gp * fint + gd * delta;
            // Never steer against the raw error: fall back to a scaled P term.
            if ((err > 0 && acc < 0) || (err < 0 && acc > 0)) begin
                acc = (longint'(cfg_guard) * gp * err) / 256;
                guard_hits++;
            end
            lim = longint'(cfg_diff_lim) * 256;
            if (acc > lim) acc = lim;
            else if (acc < -lim) acc = -lim;
            diff     = acc / 256;
            filt_q8  = 18'(f);
            prev_int = 10'(fint);
        end
        // Slow down in proportion to how hard the robot is turning.
        mag = (diff < 0) ? -diff : diff;
        cut = (cfg_diff_lim == '0) ? 0 : (mag * longint'(cfg_reduce)) / longint'(cfg_diff_lim);
        eff = longint'(cfg_base) - cut;
        if (eff < BASE_FLOOR) eff = BASE_FLOOR;
        else if (eff > BASE_CEIL) eff = BASE_CEIL;
        r.line_error  = LINE_ERR_W'(err);
        r.diff_drive  = DIFF_W'(diff);
        r.left_drive  = DRIVE_W'(clamp_wheel(eff + diff));
        r.right_drive = DRIVE_W'(clamp_wheel(eff - diff));
        return r;
    endfunction

    // Idle length for either side: mostly none, often short, now and then long.
    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(int idx);
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return REG_MASK[idx];
            2: return CFG_DATA_W'(REG_RESET[idx]);
            3: return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(0, REG_TYPICAL[idx]));
        endcase
    endfunction

    // Mostly a line of one to three sensors that drifts across the array,
    // sometimes with a hole or a stray bit, mixed with lost-line, centered
    // and fully random patterns.
    function automatic logic [SENSOR_W-1:0] next_pattern();
        int unsigned r;
        int w;
        logic [15:0] span;
        logic [SENSOR_W-1:0] pat;
        r = $urandom_range(0, 99);
        if (r < 6) return '0;
        if (r < 9) return CENTER_PAIR_MASK;
        if (r < 17) return SENSOR_W'($urandom);
        if (r < 20) line_pos = $urandom_range(0, 7);
        else line_pos = line_pos + int'($urandom_range(0, 2)) - 1;
        if (line_pos < 0) line_pos = 0;
        if (line_pos > 7) line_pos = 7;
        w    = $urandom_range(1, 3);
        span = ((16'd1 << w) - 16'd1) << line_pos;
        pat  = span[SENSOR_W-1:0];
        if (r < 30) pat = pat ^ (SENSOR_W'(1) << $urandom_range(0, 7));
        return pat;
    endfunction

    // Writes one tuning register on the next edge and updates the shadow copy.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            CFG_GAIN_P:       cfg_gain_p    = value;
            CFG_GAIN_D:       cfg_gain_d    = value;
            CFG_BASE_DRIVE:   cfg_base      = value[9:0];
            CFG_FILTER_ALPHA: cfg_alpha     = value[8:0];
            CFG_DELTA_LIMIT:  cfg_delta_lim = value[9:0];
            CFG_GUARD_RATIO:  cfg_guard     = value[8:0];
            CFG_DIFF_LIMIT:   cfg_diff_lim  = value[9:0];
            CFG_REDUCE_MAX:   cfg_reduce    = value[9:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // Waits until every queued pattern has gone in and every result has come
    // back, then lets the block settle before registers may change.
    task automatic wait_idle();
        while (pending_patterns.size() != 0 || drv_valid || expected_drive.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Driver: offers queued patterns, predicts each one the moment it is
    // accepted, and inserts random gaps between items.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            drv_valid <= 1'b0;
            gap_left = 0;
        end else begin
            next_valid = drv_valid;
            next_bits  = drv_bits;
            if (drv_valid && in_ch.ready) begin
                expected_drive.push_back(predict_drive(drv_bits));
                items_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_patterns.size() != 0) begin
                    next_bits  = pending_patterns.pop_front();
                    next_valid = 1'b1;
                    gap_left   = idle_len();
                end
            end
            drv_valid <= next_valid;
            drv_bits  <= next_bits;
        end
    end

    // Monitor: checks each accepted result against the oldest prediction and
    // throttles ready. Twice in the run it holds ready low for a long stretch
    // so the block backs up and stalls its input.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            mon_ready <= 1'b0;
        end else begin
            if (out_ch.valid && mon_ready) begin
                results_seen++;
                if (expected_drive.size() == 0) begin
                    $error("result item with no pending prediction: line_error %0d",
                           out_ch.line_error);
                    fail_count++;
                end else begin
                    want = expected_drive.pop_front();
                    if (out_ch.line_error !== want.line_error) begin
                        $error("line_error mismatch: expected %0d, got %0d",
                               want.line_error, out_ch.line_error);
                        fail_count++;
                    end
                    if (out_ch.diff_drive !== want.diff_drive) begin
                        $error("diff_drive mismatch: expected %0d, got %0d",
                               want.diff_drive, out_ch.diff_drive);
                        fail_count++;
                    end
                    if (out_ch.left_drive !== want.left_drive) begin
                        $error("left_drive mismatch: expected %0d, got %0d",
                               want.left_drive, out_ch.left_drive);
                        fail_count++;
                    end
                    if (out_ch.right_drive !== want.right_drive) begin
                        $error("right_drive mismatch: expected %0d, got %0d",
                               want.right_drive, out_ch.right_drive);
                        fail_count++;
                    end
                end
                if (results_seen == 200 || results_seen == 1000) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else if ($urandom_range(0, 99) < 20) begin
                stall_left = idle_len();
                next_ready = (stall_left == 0);
            end else begin
                next_ready = 1'b1;
            end
            mon_ready <= next_ready;
        end
    end

    // Watchdog: a run where no item moves on either side for too long is hung.
    always @(posedge i_clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("line_follow_pd_drive regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] value;

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items at the reset settings.
        foreach (DIRECTED_RESET[i]) pending_patterns.push_back(DIRECTED_RESET[i]);
        settings_run++;
        wait_idle();

        // Directed items with a sluggish filter and no D term, so the
        // filtered error lags behind a jump across the line.
        write_reg(CFG_GAIN_P, 16'h0400);
        write_reg(CFG_GAIN_D, 16'h0000);
        write_reg(CFG_BASE_DRIVE, 16'd1000);
        write_reg(CFG_FILTER_ALPHA, 16'd16);
        write_reg(CFG_DELTA_LIMIT, 16'd560);
        write_reg(CFG_GUARD_RATIO, 16'd256);
        write_reg(CFG_DIFF_LIMIT, 16'd1000);
        write_reg(CFG_REDUCE_MAX, 16'd1000);
        end_writes();
        foreach (DIRECTED_GUARD[i]) pending_patterns.push_back(DIRECTED_GUARD[i]);
        wait_idle();

        // Random phases. The first sets every register to its largest value,
        // the second clears them all (filter frozen, no gain, zero diff
        // limit), and the rest draw a fresh mix. Every fourth phase runs
        // without idling on either side.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            for (int i = 0; i < 8; i++) begin
                if (p == 0) value = REG_MASK[i];
                else if (p == 1) value = '0;
                else value = pick_reg_value(i);
                write_reg(t_cfg_idx'(i), value);
            end
            end_writes();
            no_idle = (p % 4 == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) pending_patterns.push_back(next_pattern());
            wait_idle();
        end

        // Give any stray result a chance to show up before closing.
        repeat (60) @(posedge i_clk);
        if (expected_drive.size() != 0) begin
            $error("%0d predicted results never arrived", expected_drive.size());
            fail_count++;
        end

        $display("Drove %0d sensor items under %0d register settings; %0d results checked.",
                 items_sent, settings_run, results_seen);
        $display("Sign guard taken %0d times, loop cleared by %0d patterns.",
                 guard_hits, clear_hits);
        if (fail_count == 0) begin
            $display("line_follow_pd_drive regression: pass");
        end else begin
            $display("line_follow_pd_drive regression: fail");
        end
        $finish;
    end

endmodule

// ===== line_follow_pd_drive.f =====
rtl/core/lfpd_pkg.sv
rtl/core/lfpd_if.sv
rtl/core/lfpd_mul.sv
rtl/core/lfpd_div.sv
rtl/core/line_follow_pd_drive.sv
dv/line_follow_pd_drive_test.sv
